@@ src/atrsp_pkg.sv @@
// atrsp_pkg: shared types, event codes and match patterns for the at response parser
// no dependencies; compile first

package atrsp_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_PROMPT = 8'h3E;
    localparam logic [7:0] CHR_COLON  = 8'h3A;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;

    // patterns packed with the first character in the low byte
    localparam int OK_LEN   = 2;
    localparam int ERR_LEN  = 5;
    localparam int SOK_LEN  = 7;
    localparam int IPD_LEN  = 5;
    localparam logic [8*OK_LEN-1:0]  PAT_OK  = "KO";
    localparam logic [8*ERR_LEN-1:0] PAT_ERR = "RORRE";
    localparam logic [8*SOK_LEN-1:0] PAT_SOK = "KO DNES";
    localparam logic [8*IPD_LEN-1:0] PAT_IPD = ",DPI+";

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_OK_RELEASE = 3'd1,
        EV_OK_HELD    = 3'd2,
        EV_ERROR      = 3'd3,
        EV_PROMPT     = 3'd4,
        EV_PAYLOAD    = 3'd5
    } event_t;

    typedef struct packed {
        logic step;
        logic clear;
    } det_ctrl_t;

endpackage

@@ src/atrsp_if.sv @@
// atrsp_if: valid/ready stream interfaces for received bytes and parser results
// no dependencies

interface atrsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface atrsp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] payload_byte;

    modport source (output valid, output event_res, output payload_byte, input ready);
    modport sink (input valid, input event_res, input payload_byte, output ready);
endinterface

@@ src/atrsp_detector.sv @@
// atrsp_detector: running substring detector with its own progress register
// depends on atrsp_pkg

module atrsp_detector
    import atrsp_pkg::*;
#(
    parameter int LEN = OK_LEN,
    parameter logic [8*LEN-1:0] PATTERN = PAT_OK
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  det_ctrl_t  ctrl,
    input  logic [7:0] rx_byte,
    output logic       hit
);

    localparam int PW = $clog2(LEN + 1);

    logic [PW-1:0] prog_reg;
    logic [PW-1:0] prog_next;
    logic [PW-1:0] p_eff;
    logic [PW-1:0] p_inc;

    always_comb
    begin
        p_eff = (prog_reg >= PW'(LEN)) ? '0 : prog_reg;
        if (rx_byte == PATTERN[8*p_eff +: 8])
        begin
            p_inc = p_eff + 1'b1;
        end
        else
        begin
            p_inc = (rx_byte == PATTERN[7:0]) ? PW'(1) : '0;
        end
        hit = (p_inc == PW'(LEN));

        prog_next = prog_reg;
        if (ctrl.clear || (ctrl.step && hit))
        begin
            prog_next = '0;
        end
        else if (ctrl.step)
        begin
            prog_next = p_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg <= '0;
        end
        else
        begin
            prog_reg <= prog_next;
        end
    end

endmodule

@@ src/atrsp_parser.sv @@
// atrsp_parser: line, length and payload state with the four pattern detectors
// depends on atrsp_pkg, atrsp_detector

module atrsp_parser
    import atrsp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic       send_mode,
    output event_t     event_res,
    output logic [7:0] payload_byte
);

    localparam int LB = LENGTH_BITS;

    typedef enum logic [1:0] {
        MODE_LINE = 2'd0,
        MODE_LEN  = 2'd1,
        MODE_DATA = 2'd2
    } mode_t;

    mode_t         mode_reg, mode_next;
    logic          prev_cr_reg, prev_cr_next;
    logic          first_reg, first_next;
    logic [2:0]    flags_reg, flags_next;
    logic [LB-1:0] rem_reg, rem_next;

    logic          line_mode;
    logic          do_clear;
    det_ctrl_t     det_ctrl;
    logic          hit_ok, hit_err, hit_sok, hit_ipd;
    logic [2:0]    flags_upd;
    logic [LB+3:0] prod;
    logic [LB-1:0] rem_dec;

    assign line_mode = (mode_reg != MODE_LEN) && (mode_reg != MODE_DATA);
    assign det_ctrl.step  = step && line_mode;
    assign det_ctrl.clear = step && line_mode && do_clear;

    atrsp_detector #(.LEN(OK_LEN), .PATTERN(PAT_OK)) u_det_ok
    (
        .clk(clk), .rst_n(rst_n), .ctrl(det_ctrl), .rx_byte(rx_byte), .hit(hit_ok)
    );

    atrsp_detector #(.LEN(ERR_LEN), .PATTERN(PAT_ERR)) u_det_err
    (
        .clk(clk), .rst_n(rst_n), .ctrl(det_ctrl), .rx_byte(rx_byte), .hit(hit_err)
    );

    atrsp_detector #(.LEN(SOK_LEN), .PATTERN(PAT_SOK)) u_det_sok
    (
        .clk(clk), .rst_n(rst_n), .ctrl(det_ctrl), .rx_byte(rx_byte), .hit(hit_sok)
    );

    atrsp_detector #(.LEN(IPD_LEN), .PATTERN(PAT_IPD)) u_det_ipd
    (
        .clk(clk), .rst_n(rst_n), .ctrl(det_ctrl), .rx_byte(rx_byte), .hit(hit_ipd)
    );

    // length times ten plus digit, saturating
    assign prod = ({4'b0, rem_reg} << 3) + ({4'b0, rem_reg} << 1)
                + {{LB{1'b0}}, rx_byte[3:0]};
    assign rem_dec = (rem_reg != '0) ? rem_reg - 1'b1 : '0;
    assign flags_upd = flags_reg | {hit_err, hit_sok, hit_ok};

    always_comb
    begin
        mode_next    = mode_reg;
        prev_cr_next = prev_cr_reg;
        first_next   = first_reg;
        flags_next   = flags_reg;
        rem_next     = rem_reg;
        do_clear     = 1'b0;
        event_res    = EV_NONE;
        payload_byte = 8'h00;

        unique case (mode_reg)
            MODE_LEN:
            begin
                if (rx_byte == CHR_COLON)
                begin
                    mode_next = (rem_reg == '0) ? MODE_LINE : MODE_DATA;
                end
                else if (rx_byte >= CHR_ZERO && rx_byte <= CHR_NINE)
                begin
                    rem_next = (prod[LB+3:LB] != 4'd0) ? '1 : prod[LB-1:0];
                end
            end
            MODE_DATA:
            begin
                event_res    = EV_PAYLOAD;
                payload_byte = rx_byte;
                rem_next     = rem_dec;
                if (rem_dec == '0)
                begin
                    mode_next = MODE_LINE;
                end
            end
            default:
            begin
                mode_next = MODE_LINE;
                if (!first_reg && prev_cr_reg && rx_byte == CHR_LF)
                begin
                    if (flags_upd[0])
                    begin
                        event_res = (send_mode && !flags_upd[1]) ? EV_OK_HELD : EV_OK_RELEASE;
                    end
                    else if (flags_upd[2])
                    begin
                        event_res = EV_ERROR;
                    end
                    do_clear = 1'b1;
                end
                else if (first_reg && send_mode && rx_byte == CHR_PROMPT)
                begin
                    event_res = EV_PROMPT;
                    do_clear  = 1'b1;
                end
                else if (hit_ipd)
                begin
                    mode_next = MODE_LEN;
                    rem_next  = '0;
                    do_clear  = 1'b1;
                end
                else
                begin
                    prev_cr_next = (rx_byte == CHR_CR);
                    first_next   = 1'b0;
                    flags_next   = flags_upd;
                end
                if (do_clear)
                begin
                    prev_cr_next = 1'b0;
                    first_next   = 1'b1;
                    flags_next   = 3'b000;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_LINE;
            prev_cr_reg <= 1'b0;
            first_reg   <= 1'b1;
            flags_reg   <= 3'b000;
            rem_reg     <= '0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            prev_cr_reg <= prev_cr_next;
            first_reg   <= first_next;
            flags_reg   <= flags_next;
            rem_reg     <= rem_next;
        end
    end

endmodule

@@ src/at_response_stream_parser_unit.sv @@
// channel   dir   payload                        transaction
// in_ch     in    rx_byte[7:0]                   one received modem byte
// out_ch    out   event_res[2:0], payload_byte   exactly one result per byte
// cfg       in    cfg_we, cfg_wdata[0]           send_command_mode write
//
// two-stage pipeline: input register, then parser logic into the result register
// one byte per cycle while out_ch is ready; valid rises when the result register loads
// throughput is set by the single parser pass between the two registers
// rst_n asynchronous, active low; clears control state and parser state
// a stalled out_ch holds its result; in_ch stays ready while the input register can move
// depends on atrsp_pkg, atrsp_if, atrsp_parser

module at_response_stream_parser_unit
    import atrsp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [0:0]     cfg_wdata,
    atrsp_in_if.sink       in_ch,
    atrsp_out_if.source    out_ch
);

    logic       scm_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    event_t     out_event_reg;
    logic [7:0] out_payload_reg;

    logic       advance;
    event_t     ev;
    logic [7:0] data;

    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;

    atrsp_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser
    (
        .clk(clk),
        .rst_n(rst_n),
        .step(advance),
        .rx_byte(s1_byte_reg),
        .send_mode(scm_reg),
        .event_res(ev),
        .payload_byte(data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scm_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                scm_reg <= cfg_wdata[0];
            end
            if (in_ch.valid && in_ch.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_byte_reg <= in_ch.rx_byte;
        end
        if (advance)
        begin
            out_event_reg   <= ev;
            out_payload_reg <= data;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.event_res    = out_event_reg;
    assign out_ch.payload_byte = out_payload_reg;

endmodule

@@ src/atrsp_checker.sv @@
// atrsp_checker: port-level assertions for the at response parser, bound to the top level
// depends on atrsp_pkg, at_response_stream_parser_unit

module atrsp_checker
    import atrsp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_res,
    input logic [7:0] payload_byte
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(payload_byte))
        else $error("result changed while stalled");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res <= EV_PAYLOAD)
        else $error("event code out of range");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_PAYLOAD |-> payload_byte == 8'h00)
        else $error("payload byte set without payload event");

    // no backpressure on input while result side is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without accepted transaction");

endmodule

bind at_response_stream_parser_unit atrsp_checker u_atrsp_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .event_res(out_ch.event_res),
    .payload_byte(out_ch.payload_byte)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for at_response_stream_parser_unit, byte stream in, events out
// depends on atrsp_pkg, atrsp_if and the parser rtl; predicts every result and checks in order

module tb_top;
    import atrsp_pkg::*;

    localparam int LEN_BITS = LENGTH_BITS_DEF;
    localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 50;

    typedef enum logic [1:0] {
        ST_LINE = 2'd0,
        ST_LEN  = 2'd1,
        ST_DATA = 2'd2
    } rx_state_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] data;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_wdata;

    atrsp_in_if  in_if ();
    atrsp_out_if out_if ();

    at_response_stream_parser_unit #(
        .LENGTH_BITS (LEN_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // parser shadow state
    logic            send_mode;
    rx_state_t       rx_state;
    logic            prev_cr;
    int              ok_pos;
    int              err_pos;
    int              sok_pos;
    int              ipd_pos;
    logic            seen_ok;
    logic            seen_sok;
    logic            seen_err;
    logic            line_start;
    longint unsigned bytes_left;

    logic [7:0] rx_pending[$];
    result_t    expected_events[$];

    int  tx_gap;
    int  rx_hold;
    bit  tx_gaps_on;
    bit  rx_stalls_on;
    bit  hold_request;
    int  errors;
    int  n_pushed;
    int  n_sent;
    int  n_checked;
    int  ev_count[0:5];

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 1);
        if (r < 92)
            return $urandom_range(2, 5);
        return $urandom_range(10, 30);
    endfunction

    function automatic int match_next(int pos, string pat, logic [7:0] b);
        if (pos >= pat.len())
            pos = 0;
        if (b == pat[pos])
            return pos + 1;
        return (b == pat[0]) ? 1 : 0;
    endfunction

    task automatic clear_line_state();
        prev_cr    = 1'b0;
        ok_pos     = 0;
        err_pos    = 0;
        sok_pos    = 0;
        ipd_pos    = 0;
        seen_ok    = 1'b0;
        seen_sok   = 1'b0;
        seen_err   = 1'b0;
        line_start = 1'b1;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        result_t         res;
        logic            at_start;
        logic            ipd_hit;
        longint unsigned v;
        res.ev   = EV_NONE;
        res.data = 8'h00;
        ipd_hit  = 1'b0;
        if (rx_state == ST_LEN)
        begin
            if (b == CHR_COLON)
                rx_state = (bytes_left == 0) ? ST_LINE : ST_DATA;
            else if (b >= CHR_ZERO && b <= CHR_NINE)
            begin
                v = bytes_left * 10 + longint'(b - CHR_ZERO);
                bytes_left = (v > LEN_MAX) ? LEN_MAX : v;
            end
        end
        else if (rx_state == ST_DATA)
        begin
            res.ev   = EV_PAYLOAD;
            res.data = b;
            if (bytes_left > 0)
                bytes_left--;
            if (bytes_left == 0)
                rx_state = ST_LINE;
        end
        else
        begin
            at_start = line_start;
            rx_state = ST_LINE;
            ok_pos = match_next(ok_pos, "OK", b);
            if (ok_pos == OK_LEN)
            begin
                ok_pos  = 0;
                seen_ok = 1'b1;
            end
            err_pos = match_next(err_pos, "ERROR", b);
            if (err_pos == ERR_LEN)
            begin
                err_pos  = 0;
                seen_err = 1'b1;
            end
            sok_pos = match_next(sok_pos, "SEND OK", b);
            if (sok_pos == SOK_LEN)
            begin
                sok_pos  = 0;
                seen_sok = 1'b1;
            end
            ipd_pos = match_next(ipd_pos, "+IPD,", b);
            if (ipd_pos == IPD_LEN)
            begin
                ipd_pos = 0;
                ipd_hit = 1'b1;
            end

            if (!at_start && prev_cr && b == CHR_LF)
            begin
                if (seen_ok)
                    res.ev = (send_mode && !seen_sok) ? EV_OK_HELD : EV_OK_RELEASE;
                else if (seen_err)
                    res.ev = EV_ERROR;
                clear_line_state();
            end
            else if (at_start && send_mode && b == CHR_PROMPT)
            begin
                res.ev = EV_PROMPT;
                clear_line_state();
            end
            else if (ipd_hit)
            begin
                rx_state   = ST_LEN;
                bytes_left = 0;
                clear_line_state();
            end
            else
            begin
                prev_cr    = (b == CHR_CR);
                line_start = 1'b0;
            end
        end
        expected_events.push_back(res);
    endtask

    // byte driver
    always @(posedge clk)
    begin : drive_bytes
        logic take;
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
        end
        else
        begin
            take = in_if.valid && in_if.ready;
            if (take)
            begin
                parse_byte(in_if.rx_byte);
                n_sent++;
            end
            if (in_if.valid && !take)
            begin
                // hold the offered byte
            end
            else if (tx_gap > 0)
            begin
                tx_gap--;
                in_if.valid <= 1'b0;
            end
            else if (rx_pending.size() > 0)
            begin
                in_if.valid   <= 1'b1;
                in_if.rx_byte <= rx_pending.pop_front();
                tx_gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end
            else
            begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // event monitor and checker
    always @(posedge clk)
    begin : check_events
        result_t want;
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (out_if.event_res <= EV_PAYLOAD)
                    ev_count[out_if.event_res]++;
                if (expected_events.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected transaction, expected none, %s %0d byte %02h",
                                 $time, "got event", out_if.event_res,
                                 out_if.payload_byte);
                end
                else
                begin
                    want = expected_events.pop_front();
                    n_checked++;
                    if (out_if.event_res !== want.ev)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: event_res expected %0d, got %0d",
                                     $time, want.ev, out_if.event_res);
                    end
                    if (out_if.payload_byte !== want.data)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: payload_byte expected %02h, got %02h",
                                     $time, want.data, out_if.payload_byte);
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                rx_hold = HOLD_CYCLES;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_if.ready <= 1'b0;
            end
            else if (rx_stalls_on && $urandom_range(0, 3) == 0)
            begin
                rx_hold = pick_gap();
                out_if.ready <= 1'b0;
            end
            else
            begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        n_pushed++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_junk(input int n, input bit full_range);
        for (int i = 0; i < n; i++)
            push_byte(full_range ? 8'($urandom_range(0, 255))
                                 : 8'($urandom_range(8'h20, 8'h7E)));
    endtask

    task automatic write_mode(input logic v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        send_mode = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (rx_pending.size() != 0 || in_if.valid || expected_events.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic add_token();
        int    kind;
        int    len;
        string digits;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            if ($urandom_range(0, 3) == 0)
                push_junk($urandom_range(1, 5), 1'b0);
            case ($urandom_range(0, 5))
                0: push_str("OK");
                1: push_str("ERROR");
                2: push_str("SEND OK");
                3: push_str("ERROR OK");
                4: push_str("OK ERROR");
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                push_junk($urandom_range(1, 5), 1'b0);
            push_str("\r\n");
        end
        else if (kind < 55)
        begin
            len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
            digits = $sformatf("%0d", len);
            push_str("+IPD,");
            if ($urandom_range(0, 9) == 0)
                push_byte(8'($urandom_range(8'h61, 8'h7A)));
            push_str(digits);
            if ($urandom_range(0, 9) == 0)
                push_byte(8'h20);
            push_byte(CHR_COLON);
            push_junk(len, 1'b1);
        end
        else if (kind < 65)
        begin
            push_byte(CHR_PROMPT);
            if ($urandom_range(0, 1) == 0)
                push_junk($urandom_range(1, 4), 1'b1);
        end
        else if (kind < 75)
        begin
            case ($urandom_range(0, 4))
                0: push_str("+IP");
                1: push_str("SEND O\r\n");
                2: push_str("\r\r\n");
                3: push_str("\n");
                default: push_str("O\rK\n");
            endcase
        end
        else if (kind < 99)
        begin
            push_junk($urandom_range(1, 8), 1'b1);
        end
        else
        begin
            push_junk($urandom_range(100, 160), 1'b0);
            if ($urandom_range(0, 1) == 0)
                push_str("OK");
            push_str("\r\n");
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int phase_start;
        int target;
        int rand_items;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        in_if.valid   = 1'b0;
        in_if.rx_byte = 8'h00;
        out_if.ready  = 1'b0;
        tx_gap        = 0;
        rx_hold       = 0;
        tx_gaps_on    = 1'b0;
        rx_stalls_on  = 1'b0;
        hold_request  = 1'b0;
        errors        = 0;
        n_pushed      = 0;
        n_sent        = 0;
        n_checked     = 0;
        foreach (ev_count[i])
            ev_count[i] = 0;
        send_mode  = 1'b0;
        rx_state   = ST_LINE;
        bytes_left = 0;
        clear_line_state();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes on a line with no keyword, ok beats error, error, prompt, held ok,
        // non-digit in the length, register change in the middle of a line
        write_mode(1'b0);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_str("\r\n");
        push_str("ERROROK\r\n");
        push_str("ERROR\r\n");
        wait_idle();
        write_mode(1'b1);
        push_byte(CHR_PROMPT);
        push_str("OK\r\n");
        push_str("+IPDx,");
        push_str("+IPD,x1:");
        push_byte(8'hFF);
        push_str("O");
        wait_idle();
        write_mode(1'b0);
        push_str("K\r\n");
        wait_idle();

        // random phases
        phase = 0;
        rand_items = 0;
        while (rand_items < 650)
        begin
            write_mode((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
            tx_gaps_on   = (phase % 3 != 0);
            rx_stalls_on = (phase % 4 != 1);
            if (phase == 2)
            begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
                hold_request = 1'b1;
            end
            target = $urandom_range(50, 100);
            phase_start = n_pushed;
            while (n_pushed - phase_start < target)
                add_token();
            wait_idle();
            rand_items += n_pushed - phase_start;
            phase++;
        end

        // saturated length: a wrapped count would end the payload after one byte
        write_mode(1'b0);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        push_str("+IPD,65537:");
        push_junk(4, 1'b1);
        push_str("OK\r\n");
        wait_idle();
        repeat (10) @(posedge clk);

        if (expected_events.size() != 0)
            errors++;
        $display("%0d bytes sent over %0d random phases and directed runs, %0d results checked",
                 n_sent, phase, n_checked);
        $display("events: none %0d, ok release %0d, ok held %0d, error %0d, prompt %0d, payload %0d",
                 ev_count[0], ev_count[1], ev_count[2], ev_count[3], ev_count[4], ev_count[5]);
        if (errors == 0)
            $display("** at_response_stream_parser_unit: PASSED **");
        else
            $display("** at_response_stream_parser_unit: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("timeout with %0d results outstanding", expected_events.size());
        $display("** at_response_stream_parser_unit: FAILED **");
        $finish;
    end

endmodule
